// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// If pre holds, post holds in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// If pre holds, post holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/wsd_pkg.sv =====
// Types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    localparam logic [2:0] EV_DATA   = 3'd0;
    localparam logic [2:0] EV_CLOSE  = 3'd1;
    localparam logic [2:0] EV_PING   = 3'd2;
    localparam logic [2:0] EV_TOOBIG = 3'd3;
    localparam logic [2:0] EV_UNSUP  = 3'd4;
    localparam logic [2:0] EV_EMPTY  = 3'd5;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [15:0] MAX_BINARY_LEN_RESET = 16'd4096;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic       is_binary;
        logic       last_byte;
    } res_t;

endpackage

// ===== hw/rtl/wsd_parser.sv =====
// Frame header parser and payload unmasking, one received byte per transfer.
`timescale 1ns / 1ps

module wsd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    input  logic [15:0]    max_binary_len,
    output logic           res_valid,
    output wsd_pkg::res_t  res
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [63:0] bytes_left_reg, bytes_left_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  key_index_reg, key_index_next;
    logic        skipping_reg, skipping_next;

    logic        len_done;
    logic        hdr_done;
    logic [63:0] hdr_len;
    logic        len_zero;
    logic        len_fits;
    logic        data_frame;
    logic [63:0] left_dec;
    logic        dec_zero;
    logic [7:0]  key_byte;
    logic [2:0]  hdr_event;

    // Payload length as it stands once the current header byte is taken in.
    assign hdr_len = (phase_reg == PH_HDR1) ? {57'd0, rx_byte[6:0]} :
                     ((phase_reg == PH_EXT16) || (phase_reg == PH_EXT64)) ?
                     {bytes_left_reg[55:0], rx_byte} : bytes_left_reg;

    assign left_dec = bytes_left_reg - 64'd1;
    assign dec_zero = (left_dec == 64'd0);
    assign len_zero = (hdr_len == 64'd0);
    assign len_fits = (hdr_len[63:16] == 48'd0) &&
                      (hdr_len[15:0] <= max_binary_len);
    assign data_frame = (opcode_reg == OP_TEXT) ||
                        ((opcode_reg == OP_BINARY) && len_fits);

    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        if (opcode_reg == OP_BINARY)
            hdr_event = EV_TOOBIG;
        else if (opcode_reg == OP_CLOSE)
            hdr_event = EV_CLOSE;
        else if (opcode_reg == OP_PING)
            hdr_event = EV_PING;
        else
            hdr_event = EV_UNSUP;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        opcode_next       = opcode_reg;
        mask_on_next      = mask_on_reg;
        bytes_left_next   = bytes_left_reg;
        header_count_next = header_count_reg;
        mask_key_next     = mask_key_reg;
        key_index_next    = key_index_reg;
        skipping_next     = skipping_reg;
        len_done          = 1'b0;
        hdr_done          = 1'b0;
        res_valid         = 1'b0;
        res               = '0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_on_next      = rx_byte[7];
                mask_key_next     = 32'd0;
                header_count_next = 3'd0;
                bytes_left_next   = 64'd0;
                if (rx_byte[6:0] == LEN_EXT16)
                    phase_next = PH_EXT16;
                else if (rx_byte[6:0] == LEN_EXT64)
                    phase_next = PH_EXT64;
                else
                begin
                    bytes_left_next = {57'd0, rx_byte[6:0]};
                    len_done        = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                bytes_left_next = {bytes_left_reg[55:0], rx_byte};
                if (((phase_reg == PH_EXT16) && (header_count_reg >= 3'd1)) ||
                    ((phase_reg == PH_EXT64) && (header_count_reg >= 3'd7)))
                    len_done = 1'b1;
                else
                    header_count_next = header_count_reg + 3'd1;
            end
            PH_KEY:
            begin
                mask_key_next = {mask_key_reg[23:0], rx_byte};
                if (header_count_reg >= 3'd3)
                begin
                    header_count_next = 3'd0;
                    hdr_done          = 1'b1;
                end
                else
                    header_count_next = header_count_reg + 3'd1;
            end
            PH_DATA:
            begin
                if (bytes_left_reg == 64'd0)
                begin
                    // A frame with nothing left to read: start over on a header.
                    phase_next    = PH_HDR0;
                    skipping_next = 1'b0;
                end
                else
                begin
                    bytes_left_next = left_dec;
                    if (skipping_reg)
                    begin
                        if (dec_zero)
                        begin
                            phase_next    = PH_HDR0;
                            skipping_next = 1'b0;
                        end
                    end
                    else
                    begin
                        key_index_next = key_index_reg + 2'd1;
                        if (dec_zero)
                            phase_next = PH_HDR0;
                        res_valid     = 1'b1;
                        res.event_res = EV_DATA;
                        res.data_byte = rx_byte ^ key_byte;
                        res.is_binary = (opcode_reg == OP_BINARY);
                        res.last_byte = dec_zero;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        if (len_done)
        begin
            header_count_next = 3'd0;
            if (mask_on_next)
                phase_next = PH_KEY;
            else
                hdr_done = 1'b1;
        end

        if (hdr_done)
        begin
            key_index_next = 2'd0;
            skipping_next  = 1'b0;
            if (data_frame)
            begin
                if (len_zero)
                begin
                    phase_next    = PH_HDR0;
                    res_valid     = 1'b1;
                    res.event_res = EV_EMPTY;
                    res.is_binary = (opcode_reg == OP_BINARY);
                    res.last_byte = 1'b1;
                end
                else
                    phase_next = PH_DATA;
            end
            else
            begin
                // Control, oversized and unknown frames report once, then drop their payload.
                skipping_next = 1'b1;
                phase_next    = len_zero ? PH_HDR0 : PH_DATA;
                res_valid     = 1'b1;
                res.event_res = hdr_event;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR0;
            opcode_reg       <= 4'd0;
            mask_on_reg      <= 1'b0;
            bytes_left_reg   <= 64'd0;
            header_count_reg <= 3'd0;
            mask_key_reg     <= 32'd0;
            key_index_reg    <= 2'd0;
            skipping_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            opcode_reg       <= opcode_next;
            mask_on_reg      <= mask_on_next;
            bytes_left_reg   <= bytes_left_next;
            header_count_reg <= header_count_next;
            mask_key_reg     <= mask_key_next;
            key_index_reg    <= key_index_next;
            skipping_reg     <= skipping_next;
        end
    end

endmodule

// ===== hw/rtl/wsd_out_buf.sv =====
// Result register with a skid stage in front of the output channel.
`timescale 1ns / 1ps

module wsd_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wsd_pkg::res_t  push_res,
    output logic           full,
    output logic           out_valid,
    input  logic           out_stall,
    output wsd_pkg::res_t  out_res
);
    import wsd_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No new item is taken while the skid stage is occupied.
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_res_reg <= skid_res_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_res_reg <= push_res;
            else
                skid_res_reg <= push_res;
        end
    end

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// The deframer takes one received byte per transfer and can take a byte in every clock cycle
// while in_stall is low: each byte updates the header parser state and produces at most one
// result in the same cycle, and that result lands in an output register backed by a one-entry
// skid stage. in_stall rises only when both of those hold results, that is, after the output
// side has stalled while a new result arrived; it drops again in the cycle after the output
// register hands its result on. A result appears on the output in the cycle after the byte that
// caused it when the output register is free, later when it waits behind a stalled result. Header
// events (close, ping, oversized binary, unsupported opcode, empty data frame) come out on the
// byte that completes the header; the payload bytes of those frames are consumed without any result.
// max_binary_len may be rewritten at any time the block is idle; cfg_ready is always high.
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_binary_len,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [7:0]  data_byte,
    output logic        is_binary,
    output logic        last_byte
);
    import wsd_pkg::*;

    logic [15:0] max_len_reg;
    logic        accept;
    logic        res_valid;
    res_t        res;
    res_t        out_res;
    logic        buf_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_BINARY_LEN_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= max_binary_len;
    end

    wsd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .max_binary_len (max_len_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    wsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_res  (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign event_res = out_res.event_res;
    assign data_byte = out_res.data_byte;
    assign is_binary = out_res.is_binary;
    assign last_byte = out_res.last_byte;

endmodule

// ===== hw/rtl/wsd_checker.sv =====
// Port-level checks on the deframer output, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_res,
    input logic [7:0]  data_byte,
    input logic        is_binary,
    input logic        last_byte
);
    import wsd_pkg::*;

    logic ctrl_event;

    assign ctrl_event = (event_res == EV_CLOSE) || (event_res == EV_PING) ||
                        (event_res == EV_TOOBIG) || (event_res == EV_UNSUP);

    // A stalled result stays on the port unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(event_res) && $stable(data_byte) && $stable(is_binary) && $stable(last_byte))

    `ASSERT_SAME(a_event_code, clk, rst_n, out_valid,
        event_res == EV_DATA || event_res == EV_EMPTY || ctrl_event)

    `ASSERT_SAME(a_event_no_data, clk, rst_n, out_valid && event_res != EV_DATA,
        data_byte == 8'd0)

    `ASSERT_SAME(a_ctrl_flags, clk, rst_n, out_valid && ctrl_event,
        !is_binary && !last_byte)

    `ASSERT_SAME(a_empty_last, clk, rst_n, out_valid && event_res == EV_EMPTY,
        last_byte)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
